FILE: rtl/ssme_pkg.sv
`default_nettype none

package ssme_pkg;

   // bits of each share; all but the top bit feed the carry tree
   localparam int SHARE_WIDTH = 64;

   // fixed width of a share field on the request stream
   localparam int FIELD_WIDTH = 64;
   localparam int REQ_DATA_WIDTH = 2 * FIELD_WIDTH;
   localparam int RSP_DATA_WIDTH = 8;

   localparam int TREE_LEVELS = $clog2(SHARE_WIDTH);
   localparam int LEVELS_PER_STAGE = 2;
   // index of the last register stage, stage 0 holds the generate/propagate shares
   localparam int PIPE_LAST = (TREE_LEVELS + LEVELS_PER_STAGE - 1) / LEVELS_PER_STAGE;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - 2;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_TRIPLE_A_FIRST  = 3'd0;
   localparam csr_index_type CSR_TRIPLE_B_FIRST  = 3'd1;
   localparam csr_index_type CSR_TRIPLE_C_FIRST  = 3'd2;
   localparam csr_index_type CSR_TRIPLE_A_SECOND = 3'd3;
   localparam csr_index_type CSR_TRIPLE_B_SECOND = 3'd4;
   localparam csr_index_type CSR_TRIPLE_C_SECOND = 3'd5;

   typedef struct packed {
      logic a_first;
      logic b_first;
      logic c_first;
      logic a_second;
      logic b_second;
      logic c_second;
   } triple_type;

   // live node count after a given number of tree levels
   function automatic int nodes_at(input int level);
      int n;
      int i;
      n = SHARE_WIDTH;
      for (i = 0; i < level; i++) begin
         n = (n + 1) / 2;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/shared_sum_msb_extract_core.sv
// Takes two additive shares of a 64-bit value per beat and returns two XOR shares of the top
// bit of their sum. Every AND of the carry tree is a Boolean Beaver multiply using the fixed
// triple held in the six one-bit registers (byte addresses 0x00..0x14, bit 0 only), which must
// be written while no beat is in flight. One beat is accepted per cycle unless rsp_tready is low
// with a full pipeline; a result passes one register for the generate/propagate shares,
// then one register per two carry-tree levels over the six levels. req_tready follows
// rsp_tready combinationally through the stage valid bits, so bubbles are squeezed out.
`default_nettype none

module shared_sum_msb_extract_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [63:0] share_first, [127:64] share_second
   input  logic [ssme_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] msb_share_first, [1] msb_share_second, [7:2] zero
   output logic [ssme_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ssme_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [ssme_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [ssme_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   import ssme_pkg::*;

   localparam int W = SHARE_WIDTH;

   // ---------------------------------------------------------------- registers
   triple_type    triple_ff;
   triple_type    triple_in;
   logic          csr_write;
   csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];

   always_comb begin
      triple_in = triple_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TRIPLE_A_FIRST:  triple_in.a_first  = csr_pwdata[0];
            CSR_TRIPLE_B_FIRST:  triple_in.b_first  = csr_pwdata[0];
            CSR_TRIPLE_C_FIRST:  triple_in.c_first  = csr_pwdata[0];
            CSR_TRIPLE_A_SECOND: triple_in.a_second = csr_pwdata[0];
            CSR_TRIPLE_B_SECOND: triple_in.b_second = csr_pwdata[0];
            CSR_TRIPLE_C_SECOND: triple_in.c_second = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         CSR_TRIPLE_A_FIRST:  csr_prdata[0] = triple_ff.a_first;
         CSR_TRIPLE_B_FIRST:  csr_prdata[0] = triple_ff.b_first;
         CSR_TRIPLE_C_FIRST:  csr_prdata[0] = triple_ff.c_first;
         CSR_TRIPLE_A_SECOND: csr_prdata[0] = triple_ff.a_second;
         CSR_TRIPLE_B_SECOND: csr_prdata[0] = triple_ff.b_second;
         CSR_TRIPLE_C_SECOND: csr_prdata[0] = triple_ff.c_second;
         default:             csr_prdata    = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         triple_ff <= '0;
      end else begin
         triple_ff <= triple_in;
      end
   end

   // ---------------------------------------------------------------- pipeline state
   logic [PIPE_LAST:0] valid_ff;
   logic [PIPE_LAST:0] valid_in;
   logic [W-1:0]       g1_ff [0:PIPE_LAST];
   logic [W-1:0]       g1_in [0:PIPE_LAST];
   logic [W-1:0]       g2_ff [0:PIPE_LAST];
   logic [W-1:0]       g2_in [0:PIPE_LAST];
   logic [W-1:0]       p1_ff [0:PIPE_LAST];
   logic [W-1:0]       p1_in [0:PIPE_LAST];
   logic [W-1:0]       p2_ff [0:PIPE_LAST];
   logic [W-1:0]       p2_in [0:PIPE_LAST];
   logic [PIPE_LAST:0] msb1_ff;
   logic [PIPE_LAST:0] msb1_in;
   logic [PIPE_LAST:0] msb2_ff;
   logic [PIPE_LAST:0] msb2_in;

   wire  [PIPE_LAST:0] stage_ready;
   wire  [PIPE_LAST:0] src_valid;
   wire  [W-1:0]       src_g1 [0:PIPE_LAST];
   wire  [W-1:0]       src_g2 [0:PIPE_LAST];
   wire  [W-1:0]       src_p1 [0:PIPE_LAST];
   wire  [W-1:0]       src_p2 [0:PIPE_LAST];
   wire  [PIPE_LAST:0] src_msb1;
   wire  [PIPE_LAST:0] src_msb2;

   // a stage takes a new beat when it is empty or its content moves on
   assign stage_ready[PIPE_LAST] = !valid_ff[PIPE_LAST] || rsp_tready;
   for (genvar k = 0; k < PIPE_LAST; k++) begin : g_ready
      assign stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
   end

   assign req_tready = stage_ready[0];

   // ---------------------------------------------------------------- front end
   wire [FIELD_WIDTH-1:0] share_first;
   wire [FIELD_WIDTH-1:0] share_second;
   wire [W-1:0]           front_g1;
   wire [W-1:0]           front_g2;

   assign share_first  = req_tdata[FIELD_WIDTH-1:0];
   assign share_second = req_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH];

   // node 0 is the carry in, node i+1 holds bit i
   assign front_g1[0] = 1'b0;
   assign front_g2[0] = 1'b0;
   for (genvar i = 0; i < W - 1; i++) begin : g_front
      ssme_beaver_and u_gen (
         .triple   (triple_ff),
         .x_first  (share_first[i]),
         .y_first  (1'b0),
         .x_second (1'b0),
         .y_second (share_second[i]),
         .r_first  (front_g1[i+1]),
         .r_second (front_g2[i+1])
      );
   end

   assign src_valid[0] = req_tvalid;
   assign src_g1[0]    = front_g1;
   assign src_g2[0]    = front_g2;
   assign src_p1[0]    = {share_first[W-2:0], 1'b0};
   assign src_p2[0]    = {share_second[W-2:0], 1'b0};
   assign src_msb1[0]  = share_first[W-1];
   assign src_msb2[0]  = share_second[W-1];

   // ---------------------------------------------------------------- carry tree
   wire [W-1:0] lvl_g1 [1:TREE_LEVELS];
   wire [W-1:0] lvl_g2 [1:TREE_LEVELS];
   wire [W-1:0] lvl_p1 [1:TREE_LEVELS];
   wire [W-1:0] lvl_p2 [1:TREE_LEVELS];

   for (genvar lv = 1; lv <= TREE_LEVELS; lv++) begin : g_level
      localparam int N_IN      = nodes_at(lv - 1);
      localparam int N_OUT     = nodes_at(lv);
      localparam int PAIRS     = (N_IN - 2) / 2;
      localparam int SRC_STAGE = (lv - 1) / LEVELS_PER_STAGE;

      wire [W-1:0] in_g1;
      wire [W-1:0] in_g2;
      wire [W-1:0] in_p1;
      wire [W-1:0] in_p2;
      wire         c0_first;
      wire         c0_second;

      if ((lv - 1) % LEVELS_PER_STAGE == 0) begin : g_from_reg
         assign in_g1 = g1_ff[SRC_STAGE];
         assign in_g2 = g2_ff[SRC_STAGE];
         assign in_p1 = p1_ff[SRC_STAGE];
         assign in_p2 = p2_ff[SRC_STAGE];
      end else begin : g_from_level
         assign in_g1 = lvl_g1[lv-1];
         assign in_g2 = lvl_g2[lv-1];
         assign in_p1 = lvl_p1[lv-1];
         assign in_p2 = lvl_p2[lv-1];
      end

      // carry node folds in its upper neighbor; propagate share first
      ssme_beaver_and u_carry (
         .triple   (triple_ff),
         .x_first  (in_p1[1]),
         .y_first  (in_g1[0]),
         .x_second (in_p2[1]),
         .y_second (in_g2[0]),
         .r_first  (c0_first),
         .r_second (c0_second)
      );
      assign lvl_g1[lv][0] = c0_first ^ in_g1[1];
      assign lvl_g2[lv][0] = c0_second ^ in_g2[1];
      assign lvl_p1[lv][0] = 1'b0;
      assign lvl_p2[lv][0] = 1'b0;

      for (genvar k = 1; k <= PAIRS; k++) begin : g_pair
         localparam int J = 2 * k;
         wire pg_first;
         wire pg_second;

         ssme_beaver_and u_gen (
            .triple   (triple_ff),
            .x_first  (in_p1[J+1]),
            .y_first  (in_g1[J]),
            .x_second (in_p2[J+1]),
            .y_second (in_g2[J]),
            .r_first  (pg_first),
            .r_second (pg_second)
         );
         assign lvl_g1[lv][k] = pg_first ^ in_g1[J+1];
         assign lvl_g2[lv][k] = pg_second ^ in_g2[J+1];

         ssme_beaver_and u_prop (
            .triple   (triple_ff),
            .x_first  (in_p1[J+1]),
            .y_first  (in_p1[J]),
            .x_second (in_p2[J+1]),
            .y_second (in_p2[J]),
            .r_first  (lvl_p1[lv][k]),
            .r_second (lvl_p2[lv][k])
         );
      end

      // odd count: top node passes through
      if (N_IN % 2 == 1) begin : g_odd
         assign lvl_g1[lv][N_OUT-1] = in_g1[N_IN-1];
         assign lvl_g2[lv][N_OUT-1] = in_g2[N_IN-1];
         assign lvl_p1[lv][N_OUT-1] = in_p1[N_IN-1];
         assign lvl_p2[lv][N_OUT-1] = in_p2[N_IN-1];
      end

      for (genvar k = N_OUT; k < W; k++) begin : g_unused
         assign lvl_g1[lv][k] = 1'b0;
         assign lvl_g2[lv][k] = 1'b0;
         assign lvl_p1[lv][k] = 1'b0;
         assign lvl_p2[lv][k] = 1'b0;
      end
   end

   for (genvar k = 1; k <= PIPE_LAST; k++) begin : g_stage_src
      localparam int LV = (k * LEVELS_PER_STAGE < TREE_LEVELS) ?
                          k * LEVELS_PER_STAGE : TREE_LEVELS;
      assign src_valid[k] = valid_ff[k-1];
      assign src_g1[k]    = lvl_g1[LV];
      assign src_g2[k]    = lvl_g2[LV];
      assign src_p1[k]    = lvl_p1[LV];
      assign src_p2[k]    = lvl_p2[LV];
      assign src_msb1[k]  = msb1_ff[k-1];
      assign src_msb2[k]  = msb2_ff[k-1];
   end

   // ---------------------------------------------------------------- stage registers
   always_comb begin
      for (int k = 0; k <= PIPE_LAST; k++) begin
         valid_in[k] = valid_ff[k];
         g1_in[k]    = g1_ff[k];
         g2_in[k]    = g2_ff[k];
         p1_in[k]    = p1_ff[k];
         p2_in[k]    = p2_ff[k];
         msb1_in[k]  = msb1_ff[k];
         msb2_in[k]  = msb2_ff[k];
         if (stage_ready[k]) begin
            valid_in[k] = src_valid[k];
            g1_in[k]    = src_g1[k];
            g2_in[k]    = src_g2[k];
            p1_in[k]    = src_p1[k];
            p2_in[k]    = src_p2[k];
            msb1_in[k]  = src_msb1[k];
            msb2_in[k]  = src_msb2[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      g1_ff   <= g1_in;
      g2_ff   <= g2_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      msb1_ff <= msb1_in;
      msb2_ff <= msb2_in;
   end

   // ---------------------------------------------------------------- result
   assign rsp_tvalid = valid_ff[PIPE_LAST];
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - 2){1'b0}},
                        msb2_ff[PIPE_LAST] ^ g2_ff[PIPE_LAST][0],
                        msb1_ff[PIPE_LAST] ^ g1_ff[PIPE_LAST][0]};

   // ---------------------------------------------------------------- assertions
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted request beat did not reach the first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && !stage_ready[0] |=> valid_ff[0] && $stable(g1_ff[0]) && $stable(g2_ff[0]))
      else $error("stalled first stage lost or changed its beat");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !valid_ff[PIPE_LAST-1] |=> !rsp_tvalid)
      else $error("result beat repeated after it was taken");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_index == CSR_TRIPLE_C_SECOND |=> triple_ff.c_second == $past(csr_pwdata[0]))
      else $error("triple register write not applied");

endmodule

`default_nettype wire

FILE: rtl/ssme_beaver_and.sv
`default_nettype none

module ssme_beaver_and (
   input  ssme_pkg::triple_type triple,
   input  logic                 x_first,
   input  logic                 y_first,
   input  logic                 x_second,
   input  logic                 y_second,
   output logic                 r_first,
   output logic                 r_second
);

   logic e;
   logic f;

   // masked openings of both operands
   assign e = x_first ^ triple.a_first ^ x_second ^ triple.a_second;
   assign f = y_first ^ triple.b_first ^ y_second ^ triple.b_second;

   assign r_first  = (e & f) ^ (f & triple.a_first) ^ (e & triple.b_first) ^ triple.c_first;
   assign r_second = (f & triple.a_second) ^ (e & triple.b_second) ^ triple.c_second;

endmodule

`default_nettype wire

FILE: verif/tb_shared_sum_msb_extract_core.sv
`timescale 1ns / 100ps

module tb_shared_sum_msb_extract_core;
   import ssme_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_COUNT = 8;
   localparam int BEATS_PER_PHASE = 125;
   localparam int SETTLE_CYCLES = 12;
   localparam int DIRECTED_COUNT = 16;

   typedef struct packed {
      logic first;
      logic second;
   } msb_pair_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] first;
      logic [FIELD_WIDTH-1:0] second;
      logic                   typed;
      msb_pair_type           msb;
   } share_row_type;

   localparam logic [FIELD_WIDTH-1:0] ALL_ONES = '1;
   localparam logic [FIELD_WIDTH-1:0] MOST_NEG = {1'b1, {(FIELD_WIDTH-1){1'b0}}};
   localparam logic [FIELD_WIDTH-1:0] MOST_POS = {1'b0, {(FIELD_WIDTH-1){1'b1}}};
   localparam logic [FIELD_WIDTH-1:0] ONE = 1;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_DATA_WIDTH-1:0]   req_tdata = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]   rsp_tdata;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]   csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_prdata;
   logic                        csr_pready;

   logic [31:0]                 cycle_count = '0;
   int                          error_count = 0;
   triple_type                  active_triple = '0;
   msb_pair_type                pending_msb [$];

   logic [FIELD_WIDTH-1:0] corner_values [5] = '{'0, ALL_ONES, MOST_NEG, MOST_POS, ONE};

   // rows marked typed carry their result for the reset triple, the rest go to the predictor
   share_row_type directed_rows [DIRECTED_COUNT] = '{
      '{'0,       '0,       1'b1, '{1'b0, 1'b0}},
      '{ALL_ONES, ONE,      1'b1, '{1'b0, 1'b0}},
      '{MOST_POS, ONE,      1'b1, '{1'b1, 1'b0}},
      '{MOST_NEG, MOST_NEG, 1'b1, '{1'b1, 1'b1}},
      '{MOST_NEG, '0,       1'b1, '{1'b1, 1'b0}},
      '{'0,       MOST_NEG, 1'b1, '{1'b0, 1'b1}},
      '{ALL_ONES, ALL_ONES, 1'b1, '{1'b0, 1'b1}},
      '{MOST_POS, MOST_POS, 1'b1, '{1'b1, 1'b0}},
      '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, '{1'b0, 1'b0}},
      '{64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 1'b0, '{1'b0, 1'b0}},
      '{64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '{1'b0, 1'b0}},
      '{ONE,      ALL_ONES, 1'b0, '{1'b0, 1'b0}},
      '{64'h0000_0000_FFFF_FFFF, ONE, 1'b0, '{1'b0, 1'b0}},
      '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0, '{1'b0, 1'b0}},
      '{64'hFFFF_FFFF_0000_0000, 64'h0000_0001_0000_0000, 1'b0, '{1'b0, 1'b0}},
      '{64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b0, '{1'b0, 1'b0}}
   };

   shared_sum_msb_extract_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // masked and of two xor-shared bits, returns {second party, first party}
   function automatic logic [1:0] masked_and(input logic x1, input logic y1, input logic x2,
                                             input logic y2, input triple_type t);
      logic e;
      logic f;
      e = x1 ^ t.a_first ^ x2 ^ t.a_second;
      f = y1 ^ t.b_first ^ y2 ^ t.b_second;
      return {(f & t.a_second) ^ (e & t.b_second) ^ t.c_second,
              (e & f) ^ (f & t.a_first) ^ (e & t.b_first) ^ t.c_first};
   endfunction

   function automatic msb_pair_type predict_msb(input logic [FIELD_WIDTH-1:0] s1,
                                                input logic [FIELD_WIDTH-1:0] s2,
                                                input triple_type t);
      logic [63:0]  g1;
      logic [63:0]  g2;
      logic [63:0]  p1;
      logic [63:0]  p2;
      logic [1:0]   r;
      int           i;
      int           j;
      int           k;
      int           n;
      msb_pair_type res;
      g1 = '0;
      g2 = '0;
      p1 = '0;
      p2 = '0;
      // node i+1 holds generate/propagate of bit i, node 0 is the carry in
      for (i = 0; i + 1 < SHARE_WIDTH; i++) begin
         r = masked_and(s1[i], 1'b0, 1'b0, s2[i], t);
         g1[i+1] = r[0];
         g2[i+1] = r[1];
         p1[i+1] = s1[i];
         p2[i+1] = s2[i];
      end
      n = SHARE_WIDTH;
      while (n > 1) begin
         r = masked_and(p1[1], g1[0], p2[1], g2[0], t);
         g1[0] = r[0] ^ g1[1];
         g2[0] = r[1] ^ g2[1];
         k = 1;
         for (j = 2; j + 1 < n; j += 2) begin
            r = masked_and(p1[j+1], g1[j], p2[j+1], g2[j], t);
            g1[k] = r[0] ^ g1[j+1];
            g2[k] = r[1] ^ g2[j+1];
            r = masked_and(p1[j+1], p1[j], p2[j+1], p2[j], t);
            p1[k] = r[0];
            p2[k] = r[1];
            k++;
         end
         // odd node count: last node passes through
         if (j < n) begin
            g1[k] = g1[j];
            g2[k] = g2[j];
            p1[k] = p1[j];
            p2[k] = p2[j];
            k++;
         end
         n = k;
      end
      res.first = s1[SHARE_WIDTH-1] ^ g1[0];
      res.second = s2[SHARE_WIDTH-1] ^ g2[0];
      return res;
   endfunction

   function automatic logic triple_bit(input triple_type t, input csr_index_type index);
      case (index)
         CSR_TRIPLE_A_FIRST:  return t.a_first;
         CSR_TRIPLE_B_FIRST:  return t.b_first;
         CSR_TRIPLE_C_FIRST:  return t.c_first;
         CSR_TRIPLE_A_SECOND: return t.a_second;
         CSR_TRIPLE_B_SECOND: return t.b_second;
         CSR_TRIPLE_C_SECOND: return t.c_second;
         default:             return 1'b0;
      endcase
   endfunction

   task automatic csr_access(input csr_index_type index, input logic write,
                             input logic [CSR_DATA_WIDTH-1:0] wdata,
                             output logic [CSR_DATA_WIDTH-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // upper data bits are random, only bit 0 should stick
   task automatic load_triple(input triple_type t);
      logic [CSR_DATA_WIDTH-1:0] rd;
      int                        i;
      for (i = CSR_TRIPLE_A_FIRST; i <= CSR_TRIPLE_C_SECOND; i++) begin
         csr_access(csr_index_type'(i), 1'b1,
                    ($urandom() & ~32'd1) | 32'(triple_bit(t, csr_index_type'(i))), rd);
      end
      // write to an unmapped index must not disturb anything
      csr_access(csr_index_type'($urandom_range(CSR_TRIPLE_C_SECOND + 1,
                                                (1 << CSR_INDEX_WIDTH) - 1)),
                 1'b1, $urandom(), rd);
      active_triple = t;
   endtask

   task automatic verify_triple(input triple_type t);
      logic [CSR_DATA_WIDTH-1:0] rd;
      int                        i;
      for (i = CSR_TRIPLE_A_FIRST; i <= CSR_TRIPLE_C_SECOND; i++) begin
         csr_access(csr_index_type'(i), 1'b0, '0, rd);
         if (rd !== CSR_DATA_WIDTH'(triple_bit(t, csr_index_type'(i)))) begin
            $error("triple register %0d expected %h actual %h", i,
                   CSR_DATA_WIDTH'(triple_bit(t, csr_index_type'(i))), rd);
            error_count++;
         end
      end
   endtask

   task automatic send_shares(input logic [FIELD_WIDTH-1:0] s1,
                              input logic [FIELD_WIDTH-1:0] s2, input msb_pair_type want);
      req_tvalid <= 1'b1;
      req_tdata <= {s2, s1};
      do @(posedge clock); while (!req_tready);
      pending_msb = {pending_msb, want};
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_msb.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin : check_results
      msb_pair_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_msb.size() == 0) begin
            $error("result beat with nothing expected, rsp_tdata %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_msb.pop_front();
            if (rsp_tdata[0] !== want.first) begin
               $error("msb_share_first expected %b actual %b", want.first, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[1] !== want.second) begin
               $error("msb_share_second expected %b actual %b", want.second, rsp_tdata[1]);
               error_count++;
            end
            if (rsp_tdata[RSP_DATA_WIDTH-1:2] !== '0) begin
               $error("rsp_tdata pad expected 0 actual %h", rsp_tdata[RSP_DATA_WIDTH-1:2]);
               error_count++;
            end
         end
      end
      // receiver mode follows bits 9:8 of the cycle counter
      case (cycle_count[9:8])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= 1'($urandom_range(0, 1));
         2'd2: rsp_tready <= (cycle_count[2:0] == 3'd0);
         default: rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   initial begin
      logic [FIELD_WIDTH-1:0] s1;
      logic [FIELD_WIDTH-1:0] s2;
      triple_type             t;
      msb_pair_type           want;
      int                     row;
      int                     phase;
      int                     beat;
      int                     burst_left;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      verify_triple('0);

      for (row = 0; row < DIRECTED_COUNT; row++) begin
         want = directed_rows[row].typed ? directed_rows[row].msb
                : predict_msb(directed_rows[row].first, directed_rows[row].second,
                              active_triple);
         send_shares(directed_rows[row].first, directed_rows[row].second, want);
      end
      drain_results();

      burst_left = 0;
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: t = '1;
            1: t = '0;
            2: begin
               // a consistent triple: c shares xor to a & b
               t = triple_type'($urandom_range(0, 63));
               t.c_second = t.c_first ^ ((t.a_first ^ t.a_second) & (t.b_first ^ t.b_second));
            end
            default: t = triple_type'($urandom_range(0, 63));
         endcase
         load_triple(t);
         verify_triple(t);
         for (beat = 0; beat < BEATS_PER_PHASE; beat++) begin
            s1 = {$urandom(), $urandom()};
            case ($urandom_range(0, 9))
               0, 1, 2, 3: s2 = {$urandom(), $urandom()};
               // long carry chains: propagate set almost everywhere
               4, 5: s2 = ~s1 ^ (ONE << $urandom_range(0, FIELD_WIDTH - 1));
               6: s2 = ~s1 + FIELD_WIDTH'($urandom_range(0, 2));
               7: begin
                  s1 = corner_values[$urandom_range(0, 4)];
                  s2 = corner_values[$urandom_range(0, 4)];
               end
               8: s2 = s1;
               default: begin
                  s1 = s1 & {$urandom(), $urandom()};
                  s2 = {$urandom(), $urandom()} | {$urandom(), $urandom()};
               end
            endcase
            if (burst_left == 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
               burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            send_shares(s1, s2, predict_msb(s1, s2, active_triple));
         end
         drain_results();
      end

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
